>>> sv/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the timer slot scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_UPDATE   = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_DONE  = 3'd0,
        KIND_NEWID = 3'd1,
        KIND_FULL  = 3'd2,
        KIND_FIRED = 3'd3,
        KIND_VALID = 3'd4
    } t_kind;

    // One slot as held in the table memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] delay;
        logic [31:0] interval;
        logic [47:0] start;
        logic        expired;
        logic        past_initial;
    } t_slot;

endpackage

>>> sv/timer_slot_scheduler.sv
`timescale 1ns / 1ps
// Schedule writes the new slot and then presents its result. Cancel/query scan the
// table slot by slot, reading each slot and then checking it. Update runs a compaction
// pass and then a firing pass over the slots, up to the last result; a fire waits
// while an earlier fire result is still held.
// Throughput: one item in flight; the next is accepted once the last result is taken.
// Reset (synchronous, active low) clears entry count, id counter and control.
// ----------------------------------------------------------------------------
// timer_slot_scheduler
// Ordered table of one-shot and periodic timers kept in a slot memory.
// ----------------------------------------------------------------------------
module timer_slot_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [47:0] i_now_ms,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_interval_ms,
    input  logic [31:0] i_target_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_job_id,
    output logic        o_is_valid,
    output logic        o_last
);
    import tss_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MAXRES = 16;
    localparam int NW = $clog2(MAXRES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCHED, S_FIND_RD, S_FIND, S_CMP_RD, S_CMP,
        S_FIRE_RD, S_FIRE, S_OUT, S_WAIT
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_count;
    logic [31:0]    r_last_id;
    logic [1:0]     r_cmd;
    logic [47:0]    r_now;
    logic [31:0]    r_delay, r_interval, r_target;
    logic [CW-1:0]  r_rd, r_wr;
    logic [NW-1:0]  r_nfire;
    logic           r_ovalid;
    logic [2:0]     r_kind;
    logic [31:0]    r_job;
    logic           r_isv, r_last;
    logic           r_found_done;

    logic           n_we;
    logic [AW-1:0]  n_waddr, n_raddr;
    t_slot          n_wdata, rd_slot;

    tss_table #(.SLOTS(SLOTS), .AW(AW)) u_table (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(rd_slot)
    );

    // Due check on the slot just read
    logic [31:0] lim;
    logic [48:0] diff;
    logic        due;
    always_comb begin
        lim  = (rd_slot.interval != 32'd0 && rd_slot.past_initial) ?
               rd_slot.interval : rd_slot.delay;
        diff = {1'b0, r_now} - {1'b0, rd_slot.start};
        due  = !diff[48] && (diff[47:0] >= {16'd0, lim});
    end

    logic out_free;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;

    // Memory port control
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_wr[AW-1:0];
        n_wdata = rd_slot;
        n_raddr = r_rd[AW-1:0];
        case (r_state)
            S_SCHED: begin
                n_we    = 1'b1;
                n_waddr = r_count[AW-1:0];
                n_wdata.id           = r_last_id;
                n_wdata.delay        = r_delay;
                n_wdata.interval     = r_interval;
                n_wdata.start        = r_now;
                n_wdata.expired      = 1'b0;
                n_wdata.past_initial = 1'b0;
            end
            S_FIND: begin
                if (rd_slot.id == r_target && !r_found_done && r_cmd == CMD_CANCEL) begin
                    n_we    = 1'b1;
                    n_waddr = r_wr[AW-1:0];
                    n_wdata.expired = 1'b1;
                end
            end
            S_CMP: begin
                // move live slot down
                n_we    = !rd_slot.expired;
                n_waddr = r_wr[AW-1:0];
            end
            S_FIRE: begin
                // keep the slot under test on the read port while the output stalls
                n_raddr = r_wr[AW-1:0];
                if (due && out_free) begin
                    n_we    = 1'b1;
                    n_waddr = r_wr[AW-1:0];
                    if (rd_slot.interval != 32'd0) begin
                        n_wdata.past_initial = 1'b1;
                        n_wdata.start        = r_now;
                    end else begin
                        n_wdata.expired = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_last_id <= '0;
            r_ovalid  <= 1'b0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_nfire   <= '0;
            r_found_done <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd      <= i_command;
                        r_now      <= i_now_ms;
                        r_delay    <= i_delay_ms;
                        r_interval <= i_interval_ms;
                        r_target   <= i_target_id;
                        r_rd       <= '0;
                        r_wr       <= '0;
                        r_nfire    <= '0;
                        r_found_done <= 1'b0;
                        r_isv      <= 1'b0;
                        case (t_cmd'(i_command))
                            CMD_SCHEDULE: begin
                                if (r_count >= CW'(SLOTS)) begin
                                    r_kind <= KIND_FULL;
                                    r_job  <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_last_id <= r_last_id + 32'd1;
                                    r_state   <= S_SCHED;
                                end
                            end
                            CMD_UPDATE: r_state <= S_CMP_RD;
                            default:    r_state <= S_FIND_RD;
                        endcase
                    end
                end
                S_SCHED: begin
                    r_count <= r_count + CW'(1);
                    r_kind  <= KIND_NEWID;
                    r_job   <= r_last_id;
                    r_state <= S_OUT;
                end
                // cancel / query: scan for the lowest matching slot
                S_FIND_RD: begin
                    if (r_rd >= r_count) begin
                        r_kind  <= (r_cmd == CMD_QUERY) ? KIND_VALID : KIND_DONE;
                        r_job   <= (r_cmd == CMD_QUERY) ? r_target : 32'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_wr    <= r_rd;
                        r_rd    <= r_rd + CW'(1);
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (rd_slot.id == r_target && !r_found_done) begin
                        r_found_done <= 1'b1;
                        r_isv <= (r_cmd == CMD_QUERY) && !rd_slot.expired;
                    end
                    r_state <= S_FIND_RD;
                end
                // compaction pass
                S_CMP_RD: begin
                    if (r_rd >= r_count) begin
                        r_count <= r_wr;
                        r_rd    <= '0;
                        r_state <= S_FIRE_RD;
                    end else begin
                        r_rd    <= r_rd + CW'(1);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!rd_slot.expired) begin
                        r_wr <= r_wr + CW'(1);
                    end
                    r_state <= S_CMP_RD;
                end
                // firing pass
                S_FIRE_RD: begin
                    if (r_rd >= r_count || r_nfire == NW'(MAXRES)) begin
                        if (r_nfire == '0) begin
                            r_kind  <= KIND_DONE;
                            r_job   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_wr    <= r_rd;
                        r_rd    <= r_rd + CW'(1);
                        r_state <= S_FIRE;
                    end
                end
                S_FIRE: begin
                    if (!due) begin
                        r_state <= S_FIRE_RD;
                    end else if (out_free) begin
                        // hold the fire result until the last flag is known
                        r_kind   <= KIND_FIRED;
                        r_job    <= rd_slot.id;
                        r_nfire  <= r_nfire + NW'(1);
                        r_state  <= S_FIRE_RD;
                        if (r_nfire != '0) begin
                            r_ovalid <= 1'b1;
                            r_last   <= 1'b0;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    // flush the held last fire
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The pending fire result is registered in r_kind/r_job before emission;
    // emission of the previous one uses the copy below.
    logic [31:0] r_ojob;
    logic [2:0]  r_okind;
    logic        r_oisv;
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIRE && due && out_free && r_nfire != '0)) begin
            r_ojob  <= r_job;
            r_okind <= r_kind;
            r_oisv  <= 1'b0;
        end else if ((r_state == S_OUT || r_state == S_WAIT) && out_free) begin
            r_ojob  <= r_job;
            r_okind <= r_kind;
            r_oisv  <= r_isv;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_job_id      = r_ojob;
    assign o_is_valid    = r_oisv;
    assign o_last        = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS)) else $error("entry count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_job_id) && $stable(o_last)))
        else $error("result dropped");
    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= NW'(MAXRES)) else $error("too many fires");

endmodule

>>> sv/tss_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_table
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tss_table #(
    parameter int SLOTS = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  tss_pkg::t_slot   i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output tss_pkg::t_slot   o_rdata
);
    import tss_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer slot scheduler: a queue-fed driver, a
// monitor that compares each result with a predicted timer table, random gaps.
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    localparam int SLOTS     = 16;
    localparam int MAX_FIRES = 16;
    localparam int LIMIT     = 1000000;

    typedef struct {
        t_cmd        cmd;
        logic [47:0] now;
        logic [31:0] delay;
        logic [31:0] interval;
        logic [31:0] target;
    } t_req;

    typedef struct {
        t_kind       kind;
        logic [31:0] id;
        logic        valid;
        logic        last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = '0;
    logic [47:0] i_now_ms = '0;
    logic [31:0] i_delay_ms = '0;
    logic [31:0] i_interval_ms = '0;
    logic [31:0] i_target_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_result_kind;
    logic [31:0] o_job_id;
    logic        o_is_valid;
    logic        o_last;

    timer_slot_scheduler #(.SLOTS(SLOTS)) i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predicted timer table
    logic [31:0] tm_id[SLOTS];
    logic [31:0] tm_delay[SLOTS];
    logic [31:0] tm_interval[SLOTS];
    logic [47:0] tm_start[SLOTS];
    logic        tm_expired[SLOTS];
    logic        tm_past[SLOTS];
    int          tm_count = 0;
    logic [31:0] id_counter = '0;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   fires_seen = 0;
    int   fulls_seen = 0;
    int   cycles = 0;
    int   hold_off = 0;
    bit   stim_done = 0;

    function automatic t_res mk(t_kind k, logic [31:0] id, logic v, logic l);
        t_res r;
        r.kind = k; r.id = id; r.valid = v; r.last = l;
        return r;
    endfunction

    function automatic int find_timer(logic [31:0] id);
        for (int i = 0; i < tm_count; i++)
            if (tm_id[i] == id) return i;
        return -1;
    endfunction

    task automatic predict_timers(t_req q);
        int s, w, n;
        logic [31:0] lim;
        n = 0;
        w = 0;
        case (q.cmd)
            CMD_SCHEDULE: begin
                if (tm_count >= SLOTS) begin
                    expected_results.push_back(mk(KIND_FULL, '0, 1'b0, 1'b1));
                end else begin
                    id_counter++;
                    tm_id[tm_count] = id_counter;
                    tm_delay[tm_count] = q.delay;
                    tm_interval[tm_count] = q.interval;
                    tm_start[tm_count] = q.now;
                    tm_expired[tm_count] = 1'b0;
                    tm_past[tm_count] = 1'b0;
                    tm_count++;
                    expected_results.push_back(mk(KIND_NEWID, id_counter, 1'b0, 1'b1));
                end
            end
            CMD_UPDATE: begin
                // Drop expired entries, keeping order
                for (int i = 0; i < tm_count; i++) begin
                    if (!tm_expired[i]) begin
                        tm_id[w] = tm_id[i]; tm_delay[w] = tm_delay[i];
                        tm_interval[w] = tm_interval[i]; tm_start[w] = tm_start[i];
                        tm_expired[w] = 1'b0; tm_past[w] = tm_past[i];
                        w++;
                    end
                end
                tm_count = w;
                for (int i = 0; i < tm_count && n < MAX_FIRES; i++) begin
                    lim = (tm_interval[i] != 0 && tm_past[i]) ? tm_interval[i] : tm_delay[i];
                    if (q.now >= tm_start[i] && (q.now - tm_start[i]) >= {16'd0, lim}) begin
                        if (tm_interval[i] != 0) begin
                            tm_past[i] = 1'b1;
                            tm_start[i] = q.now;
                        end else begin
                            tm_expired[i] = 1'b1;
                        end
                        expected_results.push_back(mk(KIND_FIRED, tm_id[i], 1'b0, 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    expected_results.push_back(mk(KIND_DONE, '0, 1'b0, 1'b1));
                else
                    expected_results[$].last = 1'b1;
            end
            CMD_CANCEL: begin
                s = find_timer(q.target);
                if (s >= 0) tm_expired[s] = 1'b1;
                expected_results.push_back(mk(KIND_DONE, '0, 1'b0, 1'b1));
            end
            default: begin
                s = find_timer(q.target);
                expected_results.push_back(mk(KIND_VALID, q.target,
                    (s >= 0 && !tm_expired[s]), 1'b1));
            end
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stimulus generation
    logic [47:0] clock_ms = 48'd1000;

    function automatic t_req mkreq(t_cmd c, logic [47:0] now, logic [31:0] d,
                                   logic [31:0] iv, logic [31:0] t);
        t_req q;
        q.cmd = c; q.now = now; q.delay = d; q.interval = iv; q.target = t;
        return q;
    endfunction

    function automatic logic [31:0] rand_small_or_big();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            2: return 32'd0;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic logic [15:0] u16();
        return $urandom();
    endfunction

    // Rough count of ids issued so far, for targets near live ids
    function automatic logic [31:0] id_hint();
        int n;
        n = 0;
        foreach (pending_reqs[k]) if (pending_reqs[k].cmd == CMD_SCHEDULE) n++;
        return n;
    endfunction

    initial begin
        t_req q;
        // Directed: full table, extremes, cancel, query, backwards time
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(mkreq(CMD_SCHEDULE, 48'd100, i[31:0] * 3,
                (i % 2) ? 32'd5 : 32'd0, $urandom()));
        pending_reqs.push_back(mkreq(CMD_QUERY, 48'd100, $urandom(), $urandom(), 32'd3));
        pending_reqs.push_back(mkreq(CMD_CANCEL, 48'd100, $urandom(), $urandom(), 32'd3));
        pending_reqs.push_back(mkreq(CMD_QUERY, 48'd100, $urandom(), $urandom(), 32'd3));
        pending_reqs.push_back(mkreq(CMD_CANCEL, 48'd100, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mkreq(CMD_UPDATE, 48'd50, 0, 0, 0));
        pending_reqs.push_back(mkreq(CMD_UPDATE, 48'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(mkreq(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mkreq(CMD_SCHEDULE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 0));
        pending_reqs.push_back(mkreq(CMD_QUERY, 48'd0, 0, 0, 32'd0));
        // Random: schedules, updates, cancels and queries with time advancing, some noise
        for (int i = 0; i < 434; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                clock_ms = $urandom_range(0, 2) == 0 ? clock_ms - 48'd20
                                                    : {$urandom(), 16'(u16())};
            else
                clock_ms = clock_ms + $urandom_range(0, 25);
            if (r < 30)
                q = mkreq(CMD_SCHEDULE, clock_ms, rand_small_or_big(),
                    ($urandom_range(0, 2) == 0) ? 32'd0 : rand_small_or_big(), $urandom());
            else if (r < 65)
                q = mkreq(CMD_UPDATE, clock_ms, $urandom(), $urandom(), $urandom());
            else
                q = mkreq(r < 82 ? CMD_CANCEL : CMD_QUERY, clock_ms, $urandom(), $urandom(),
                    ($urandom_range(0, 9) == 0) ? $urandom()
                        : id_hint() - $urandom_range(0, 20));
            pending_reqs.push_back(q);
        end
        stim_done = 1;
    end

    // Acceptance seen at the rising edge; the driver holds an offered transaction until it is accepted
    logic o_ready_s = 1'b0;
    always @(posedge i_clk) o_ready_s <= i_valid && o_ready ? 1'b1 : (i_valid ? 1'b0 : 1'b1);

    // Driver
    int drv_gap = 0;
    int sent = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready_s) begin
                // hold the offered transaction
            end else if (drv_gap > 0) begin
                i_valid <= 1'b0;
                drv_gap <= drv_gap - 1;
            end else if (pending_reqs.size() > 0 && stim_done) begin
                i_valid <= 1'b1;
                i_command <= pending_reqs[0].cmd;
                i_now_ms <= pending_reqs[0].now;
                i_delay_ms <= pending_reqs[0].delay;
                i_interval_ms <= pending_reqs[0].interval;
                i_target_id <= pending_reqs[0].target;
                predict_timers(pending_reqs.pop_front());
                sent <= sent + 1;
                drv_gap <= gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with one long hold-off to fill the block
    int rcv_gap = 0;
    always @(negedge i_clk) begin
        if (sent == 40 && hold_off == 0) begin
            hold_off <= 1;
            rcv_gap <= 300;
            i_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rcv_gap <= gap_len();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (o_result_kind == KIND_FIRED) fires_seen <= fires_seen + 1;
            if (o_result_kind == KIND_FULL) fulls_seen <= fulls_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result kind=%0d id=%0d", o_result_kind, o_job_id);
            end else begin
                e = expected_results.pop_front();
                if (o_result_kind !== e.kind || o_job_id !== e.id ||
                    o_is_valid !== e.valid || o_last !== e.last) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp kind=%0d id=%0d v=%0d l=%0d, got %0d %0d %0d %0d",
                            e.kind, e.id, e.valid, e.last,
                            o_result_kind, o_job_id, o_is_valid, o_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (stim_done && pending_reqs.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
        $display("covered %0d results, %0d fires, %0d table-full answers",
            results_seen, fires_seen, fulls_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

>>> timer_slot_scheduler.f
sv/tss_pkg.sv
sv/tss_table.sv
sv/timer_slot_scheduler.sv
tb/tb.sv
